>>> rtl/core/gab_pkg.sv
// ============================================================================
// gab_pkg: shared types and constants of the alpha-plane shadow blur
// Field widths, register codes, the configuration bundle and the command and
// status groups between the controller and the datapath.
// ============================================================================
package gab_pkg;

    // Field widths fixed by the item and register formats.
    localparam int COORD_W  = 7;
    localparam int ALPHA_W  = 8;
    localparam int DIM_W    = 7;
    localparam int WEIGHT_W = 16;
    localparam int WXY_W    = 2 * WEIGHT_W;
    localparam int PROD_W   = WXY_W + ALPHA_W;
    // Signed tap coordinate: covers a shadow coordinate minus twice the radius.
    localparam int TAP_W    = COORD_W + 2;
    // Window counters cover 0 .. 2*RADIUS for every supported radius (1 to 3).
    localparam int CNT_W    = 3;
    // 49 taps of 8 x 32 bit products stay below 2^46.
    localparam int ACC_W    = 46;
    localparam int FRAC_W   = 32;
    localparam int NUM_W    = 4;

    // Configuration port geometry.
    localparam int APB_AW   = 5;
    localparam int APB_DW   = 32;

    localparam logic [DIM_W-1:0] RST_IMAGE_DIM = DIM_W'(64);
    localparam logic [ALPHA_W-1:0] ALPHA_MAX   = '1;

    // Register indexes of the configuration port.
    typedef enum logic [2:0] {
        REG_IMAGE_WIDTH  = 3'd0,
        REG_IMAGE_HEIGHT = 3'd1,
        REG_WEIGHT_CTR   = 3'd2,
        REG_WEIGHT_ONE   = 3'd3,
        REG_WEIGHT_TWO   = 3'd4,
        REG_WEIGHT_THREE = 3'd5
    } t_reg_idx;

    // Input command codes.
    typedef enum logic {
        CMD_LOAD    = 1'b0,
        CMD_COMPUTE = 1'b1
    } t_command;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_TAP   = 2'd1,
        ST_DRAIN = 2'd2
    } t_state;

    typedef struct packed {
        logic [DIM_W-1:0]                     image_width;
        logic [DIM_W-1:0]                     image_height;
        logic [NUM_W-1:0][WEIGHT_W-1:0]       weight;
    } t_cfg;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             load_wr;
        logic             start;
        logic             tap_valid;
        logic [CNT_W-1:0] cx;
        logic [CNT_W-1:0] cy;
        logic             out_load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic pipe_busy;
        logic out_free;
    } t_status;

endpackage

>>> rtl/core/gaussian_alpha_blur_top.sv
// ============================================================================
// gaussian_alpha_blur_top: drop-shadow Gaussian blur of an alpha plane
// Frame store of loaded alpha and a separable-weight window accumulator.
// ============================================================================
// Use of the block:
// The slave stream carries requests. tuser selects the kind: a load writes
// one alpha at (col, row) of the frame store and gives no result; a compute
// names a shadow pixel whose window centre is image pixel (col-RADIUS,
// row-RADIUS) and gives one result on the master stream.
// A compute walks the window one tap per cycle, one store read and one
// multiply-accumulate per tap, and holds the request stream through the
// accepting cycle, the window taps, the pipeline drain and the hand-off to
// the output register. The tap loop over the single store read port sets
// the length of a compute.
// A finished result waits in the output register; a stalled receiver holds
// it, and a compute that finishes behind it waits until the register frees.
// Loads and a further compute are taken while a result waits.
// Reset restores the register defaults (64 x 64, zero weights) and empties
// the pipeline; the frame store is not cleared and must be loaded first.
// Configuration is written over the APB-style port; the user must write it only while the block is idle (not enforced).
// ============================================================================
module gaussian_alpha_blur_top #(
    parameter int RADIUS     = 3,
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Request stream.
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [23:0]                   i_s_tdata,   // col[6:0], row[13:7], alpha_in[21:14]
    input  logic                          i_s_tuser,   // command[0]
    // Result stream.
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [23:0]                   o_m_tdata,   // shadow_alpha[7:0], out_col[14:8],
                                                       // out_row[21:15]
    // Configuration port.
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gab_pkg::APB_AW-1:0]    paddr,
    input  logic [gab_pkg::APB_DW-1:0]    pwdata,
    output logic [gab_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);

    gab_pkg::t_cfg                  cfg;
    gab_pkg::t_cmd                  cmd;
    gab_pkg::t_status               status;
    logic [gab_pkg::ALPHA_W-1:0]    shadow_alpha;
    logic [gab_pkg::COORD_W-1:0]    out_col, out_row;

    gab_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    gab_ctrl #(
        .RADIUS (RADIUS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_command  (i_s_tuser),
        .o_s_tready (o_s_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    gab_datapath #(
        .RADIUS     (RADIUS),
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_col          (i_s_tdata[6:0]),
        .i_row          (i_s_tdata[13:7]),
        .i_alpha_in     (i_s_tdata[21:14]),
        .i_m_tready     (i_m_tready),
        .o_m_tvalid     (o_m_tvalid),
        .o_shadow_alpha (shadow_alpha),
        .o_out_col      (out_col),
        .o_out_row      (out_row)
    );

    // Pack the result fields, lowest field first.
    assign o_m_tdata = {2'b00, out_row, out_col, shadow_alpha};

endmodule

>>> rtl/core/gab_regs.sv
// ============================================================================
// gab_regs: configuration register file
// Holds the image size and the four 1D weights, written and read over the
// APB-style port.
// ============================================================================
module gab_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gab_pkg::APB_AW-1:0]    paddr,
    input  logic [gab_pkg::APB_DW-1:0]    pwdata,
    output logic [gab_pkg::APB_DW-1:0]    prdata,
    output logic                          pready,
    output gab_pkg::t_cfg                 o_cfg
);

    gab_pkg::t_cfg    r_cfg;
    gab_pkg::t_reg_idx reg_idx;
    logic             wr_en;

    assign pready  = 1'b1;
    assign reg_idx = gab_pkg::t_reg_idx'(paddr[4:2]);
    assign wr_en   = psel && penable && pwrite && pready;
    assign o_cfg   = r_cfg;

    // Register writes; an index beyond the list is dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.image_width  <= gab_pkg::RST_IMAGE_DIM;
            r_cfg.image_height <= gab_pkg::RST_IMAGE_DIM;
            r_cfg.weight       <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                gab_pkg::REG_IMAGE_WIDTH:
                    r_cfg.image_width <= pwdata[gab_pkg::DIM_W-1:0];
                gab_pkg::REG_IMAGE_HEIGHT:
                    r_cfg.image_height <= pwdata[gab_pkg::DIM_W-1:0];
                gab_pkg::REG_WEIGHT_CTR:
                    r_cfg.weight[0] <= pwdata[gab_pkg::WEIGHT_W-1:0];
                gab_pkg::REG_WEIGHT_ONE:
                    r_cfg.weight[1] <= pwdata[gab_pkg::WEIGHT_W-1:0];
                gab_pkg::REG_WEIGHT_TWO:
                    r_cfg.weight[2] <= pwdata[gab_pkg::WEIGHT_W-1:0];
                gab_pkg::REG_WEIGHT_THREE:
                    r_cfg.weight[3] <= pwdata[gab_pkg::WEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // Read-back of the addressed register.
    always_comb begin
        unique case (reg_idx)
            gab_pkg::REG_IMAGE_WIDTH:  prdata = gab_pkg::APB_DW'(r_cfg.image_width);
            gab_pkg::REG_IMAGE_HEIGHT: prdata = gab_pkg::APB_DW'(r_cfg.image_height);
            gab_pkg::REG_WEIGHT_CTR:   prdata = gab_pkg::APB_DW'(r_cfg.weight[0]);
            gab_pkg::REG_WEIGHT_ONE:   prdata = gab_pkg::APB_DW'(r_cfg.weight[1]);
            gab_pkg::REG_WEIGHT_TWO:   prdata = gab_pkg::APB_DW'(r_cfg.weight[2]);
            gab_pkg::REG_WEIGHT_THREE: prdata = gab_pkg::APB_DW'(r_cfg.weight[3]);
            default:                   prdata = '0;
        endcase
    end

endmodule

>>> rtl/core/gab_ctrl.sv
// ============================================================================
// gab_ctrl: sequencing controller
// Takes requests, steps the window counters over every tap of a compute and
// hands the finished sum to the output register.
// ============================================================================
module gab_ctrl #(
    parameter int RADIUS = 3
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    input  logic              i_command,
    output logic              o_s_tready,
    input  gab_pkg::t_status  i_status,
    output gab_pkg::t_cmd     o_cmd
);

    localparam logic [gab_pkg::CNT_W-1:0] CNT_LAST = gab_pkg::CNT_W'(2 * RADIUS);

    gab_pkg::t_state              r_state, n_state;
    logic [gab_pkg::CNT_W-1:0]    r_cx, n_cx;
    logic [gab_pkg::CNT_W-1:0]    r_cy, n_cy;
    logic                         accept;

    // State and window counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gab_pkg::ST_IDLE;
            r_cx    <= '0;
            r_cy    <= '0;
        end else begin
            r_state <= n_state;
            r_cx    <= n_cx;
            r_cy    <= n_cy;
        end
    end

    assign accept = i_s_tvalid && o_s_tready;

    // Next state and commands.
    always_comb begin
        n_state    = r_state;
        n_cx       = r_cx;
        n_cy       = r_cy;
        o_s_tready = 1'b0;
        o_cmd      = '0;
        o_cmd.cx   = r_cx;
        o_cmd.cy   = r_cy;
        unique case (r_state)
            gab_pkg::ST_IDLE: begin
                o_s_tready = 1'b1;
                if (accept) begin
                    if (gab_pkg::t_command'(i_command) == gab_pkg::CMD_COMPUTE) begin
                        o_cmd.start = 1'b1;
                        n_cx        = '0;
                        n_cy        = '0;
                        n_state     = gab_pkg::ST_TAP;
                    end else begin
                        o_cmd.load_wr = 1'b1;
                    end
                end
            end
            gab_pkg::ST_TAP: begin
                o_cmd.tap_valid = 1'b1;
                if (r_cx == CNT_LAST) begin
                    n_cx = '0;
                    if (r_cy == CNT_LAST) begin
                        n_state = gab_pkg::ST_DRAIN;
                    end else begin
                        n_cy = r_cy + 1'b1;
                    end
                end else begin
                    n_cx = r_cx + 1'b1;
                end
            end
            gab_pkg::ST_DRAIN: begin
                // Wait for the last product to land, then for room at the output.
                if (!i_status.pipe_busy && i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = gab_pkg::ST_IDLE;
                end
            end
            default: n_state = gab_pkg::ST_IDLE;
        endcase
    end

endmodule

>>> rtl/core/gab_datapath.sv
// ============================================================================
// gab_datapath: frame store, tap pipeline and output register
// Stores loaded alpha, reads one window tap per cycle, weights it and
// accumulates, then saturates the sum into the output register.
// ============================================================================
module gab_datapath #(
    parameter int RADIUS     = 3,
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  gab_pkg::t_cfg                     i_cfg,
    input  gab_pkg::t_cmd                     i_cmd,
    output gab_pkg::t_status                  o_status,
    input  logic [gab_pkg::COORD_W-1:0]       i_col,
    input  logic [gab_pkg::COORD_W-1:0]       i_row,
    input  logic [gab_pkg::ALPHA_W-1:0]       i_alpha_in,
    input  logic                              i_m_tready,
    output logic                              o_m_tvalid,
    output logic [gab_pkg::ALPHA_W-1:0]       o_shadow_alpha,
    output logic [gab_pkg::COORD_W-1:0]       o_out_col,
    output logic [gab_pkg::COORD_W-1:0]       o_out_row
);

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int TAP_W  = gab_pkg::TAP_W;
    localparam int CNT_W  = gab_pkg::CNT_W;
    localparam logic [CNT_W-1:0] CNT_RAD = CNT_W'(RADIUS);

    logic [gab_pkg::ALPHA_W-1:0]  mem [DEPTH];

    logic [gab_pkg::COORD_W-1:0]  r_col, r_row;
    logic [gab_pkg::ALPHA_W-1:0]  r_rd_data;
    logic [gab_pkg::WXY_W-1:0]    r_wyx;
    logic                         r_tap_in;
    logic                         r_v1, r_v2;
    logic [gab_pkg::PROD_W-1:0]   r_prod;
    logic [gab_pkg::ACC_W-1:0]    r_acc;
    logic                         r_out_valid;
    logic [gab_pkg::ALPHA_W-1:0]  r_out_alpha;
    logic [gab_pkg::COORD_W-1:0]  r_out_col, r_out_row;

    logic                         store_ok;
    logic [ADDR_W-1:0]            wr_addr, rd_addr;
    logic signed [TAP_W-1:0]      tap_x, tap_y;
    logic                         x_ok, y_ok;
    logic [CNT_W-1:0]             dist_x, dist_y;
    logic [gab_pkg::WEIGHT_W-1:0] wx, wy;
    logic [gab_pkg::ACC_W-gab_pkg::FRAC_W-1:0] acc_int;

    // Load path: drop loads that fall outside the store.
    assign store_ok = (32'(i_col) < 32'(MAX_WIDTH)) && (32'(i_row) < 32'(MAX_HEIGHT));
    assign wr_addr  = ADDR_W'(ADDR_W'(i_row) * ADDR_W'(MAX_WIDTH) + ADDR_W'(i_col));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_wr && store_ok) begin
            mem[wr_addr] <= i_alpha_in;
        end
    end

    // Tap position: centre sits at shadow coordinate minus the radius.
    assign tap_x = $signed(TAP_W'(r_col)) + $signed(TAP_W'(i_cmd.cx))
                 - $signed(TAP_W'(2 * RADIUS));
    assign tap_y = $signed(TAP_W'(r_row)) + $signed(TAP_W'(i_cmd.cy))
                 - $signed(TAP_W'(2 * RADIUS));

    // A tap counts only inside the active image, itself clipped to the store.
    assign x_ok = !tap_x[TAP_W-1] && (32'($unsigned(tap_x)) < 32'(i_cfg.image_width))
                && (32'($unsigned(tap_x)) < 32'(MAX_WIDTH));
    assign y_ok = !tap_y[TAP_W-1] && (32'($unsigned(tap_y)) < 32'(i_cfg.image_height))
                && (32'($unsigned(tap_y)) < 32'(MAX_HEIGHT));

    assign rd_addr = ADDR_W'(ADDR_W'($unsigned(tap_y)) * ADDR_W'(MAX_WIDTH)
                   + ADDR_W'($unsigned(tap_x)));

    // Distance from the window centre selects the 1D weights.
    assign dist_x = (i_cmd.cx >= CNT_RAD) ? (i_cmd.cx - CNT_RAD) : (CNT_RAD - i_cmd.cx);
    assign dist_y = (i_cmd.cy >= CNT_RAD) ? (i_cmd.cy - CNT_RAD) : (CNT_RAD - i_cmd.cy);
    assign wx     = i_cfg.weight[dist_x[1:0]];
    assign wy     = i_cfg.weight[dist_y[1:0]];

    // Capture the coordinates of a compute request.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_col <= i_col;
            r_row <= i_row;
        end
    end

    // First stage: store read and the 2D weight.
    always_ff @(posedge i_clk) begin
        r_rd_data <= mem[rd_addr];
        r_wyx     <= wy * wx;
        r_tap_in  <= x_ok && y_ok;
    end

    // Second stage: weighted alpha.
    always_ff @(posedge i_clk) begin
        r_prod <= r_tap_in ? (gab_pkg::PROD_W'(r_rd_data) * gab_pkg::PROD_W'(r_wyx)) : '0;
    end

    // Pipeline occupancy and the accumulator.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.tap_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_acc <= '0;
        end else if (r_v2) begin
            r_acc <= r_acc + gab_pkg::ACC_W'(r_prod);
        end
    end

    // Drop the fraction and saturate.
    assign acc_int = r_acc[gab_pkg::ACC_W-1:gab_pkg::FRAC_W];

    // Output register: a result waits here until the receiver takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_alpha <= (acc_int > (gab_pkg::ACC_W - gab_pkg::FRAC_W)'(gab_pkg::ALPHA_MAX))
                         ? gab_pkg::ALPHA_MAX : acc_int[gab_pkg::ALPHA_W-1:0];
            r_out_col   <= r_col;
            r_out_row   <= r_row;
        end
    end

    assign o_status.pipe_busy = r_v1 || r_v2;
    assign o_status.out_free  = !r_out_valid || i_m_tready;
    assign o_m_tvalid         = r_out_valid;
    assign o_shadow_alpha     = r_out_alpha;
    assign o_out_col          = r_out_col;
    assign o_out_row          = r_out_row;

endmodule
